/* design/srtl_pkg.sv */
// Shared types and codes for the sorted range table lookup block.
// No dependencies; every other design file refers to this package by scoped names.
package srtl_pkg;

    localparam int ADDR_W = 64;
    localparam int LEN_W  = 32;
    localparam int KIND_W = 4;
    localparam int POS_W  = 6;
    localparam int OP_W   = 2;
    localparam int ST_W   = 2;

    // Stream payload widths, padded to whole bytes
    localparam int S_TDATA_W = 136;
    localparam int M_TDATA_W = 112;

    // Operation codes
    localparam logic [OP_W-1:0] OP_INSERT  = 2'd0;
    localparam logic [OP_W-1:0] OP_CONTAIN = 2'd1;
    localparam logic [OP_W-1:0] OP_NEARBY  = 2'd2;

    // Status codes
    localparam logic [ST_W-1:0] ST_OK   = 2'd0;
    localparam logic [ST_W-1:0] ST_NONE = 2'd1;
    localparam logic [ST_W-1:0] ST_FULL = 2'd2;

    typedef struct packed {
        logic [ADDR_W-1:0] base;
        logic [LEN_W-1:0]  len;
        logic [KIND_W-1:0] kind;
    } t_entry;

    typedef struct packed {
        logic             have;
        logic [POS_W-1:0] pos;
        t_entry           entry;
    } t_cand;

    typedef struct packed {
        logic [ST_W-1:0]  status;
        logic [POS_W-1:0] pos;
        t_entry           entry;
    } t_result;

    // Per-cell control from the sequencer
    typedef struct packed {
        logic cmp;       // compare stored base against the incoming address
        logic ins;       // commit an insert this cycle
        logic occ;       // cell lies below the fill count
        logic at_count;  // cell is the first free slot
    } t_cell_ctl;

    // Flags seen from the neighboring cells
    typedef struct packed {
        logic prev_ge;
        logic prev_lt;
        logic next_le;
        logic next_lt;
    } t_nbr;

    // Registered compare flags of one cell, already gated by occupancy
    typedef struct packed {
        logic le;
        logic lt;
        logic ge;
    } t_flags;

    // Boundary marks of one cell
    typedef struct packed {
        logic c_prev;  // last entry with base <= address
        logic p_prev;  // last entry with base <  address
        logic nxt_gt;  // first entry with base >= address, and it is above it
    } t_sel;

endpackage

/* design/sorted_range_table_lookup_top.sv */
// Top level of the sorted range table lookup: sequencer, row of slot cells, output register.
// Depends on srtl_pkg, srtl_cell, srtl_pick and srtl_merge.
//
//  channel   | dir | handshake                     | payload
//  ----------+-----+-------------------------------+-----------------------------------------
//  s_axis    | in  | s_axis_tvalid / s_axis_tready | tuser: operation; tdata: item fields
//  m_axis    | out | m_axis_tvalid / m_axis_tready | tuser: status; tdata: result fields
//
// Each item passes through select, distance and decide steps: the cells compare all slots as
// the beat is accepted, the boundary slots are picked (and an insert shifts the row) in the
// select step, the distances are registered in the distance step, and the result is decided
// and loaded into the output register at the end of the decide step. A new beat is accepted
// while idle or in that last step, so a new item is not taken before the last one is decided.
// A stalled result holds in the output register; the item behind it waits in its last step.
// Reset clears the fill count and control state only; table slots need no clearing.
module sorted_range_table_lookup_top #(
    parameter int TABLE_DEPTH = 64
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // [63:0] address, [95:64] range_size, [99:96] range_kind, [131:100] max_distance
    input  logic [srtl_pkg::S_TDATA_W-1:0]     s_axis_tdata,
    // [1:0] operation
    input  logic [srtl_pkg::OP_W-1:0]          s_axis_tuser,
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // [5:0] entry_position, [69:6] entry_base, [101:70] entry_length, [105:102] entry_kind
    output logic [srtl_pkg::M_TDATA_W-1:0]     m_axis_tdata,
    // [1:0] status
    output logic [srtl_pkg::ST_W-1:0]          m_axis_tuser
);

    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
    localparam int IDX_W = $clog2(TABLE_DEPTH);
    localparam int RES_W = $bits(srtl_pkg::t_result);

    localparam logic [1:0] PH_IDLE = 2'd0;
    localparam logic [1:0] PH_SEL  = 2'd1;
    localparam logic [1:0] PH_DIFF = 2'd2;
    localparam logic [1:0] PH_DEC  = 2'd3;

    logic [1:0]                    r_phase, n_phase;
    logic [CNT_W-1:0]              r_count, n_count;
    logic                          r_out_valid, n_out_valid;
    srtl_pkg::t_result             r_out, n_out;

    logic [srtl_pkg::OP_W-1:0]     r_op;
    logic [srtl_pkg::ADDR_W-1:0]   r_addr;
    logic [srtl_pkg::LEN_W-1:0]    r_size;
    logic [srtl_pkg::KIND_W-1:0]   r_kind;
    logic [srtl_pkg::LEN_W-1:0]    r_thr;

    srtl_pkg::t_cand               r_cand_a, n_cand_a;
    srtl_pkg::t_cand               r_cand_b, n_cand_b;
    logic [srtl_pkg::POS_W-1:0]    r_ins_pos, n_ins_pos;
    logic                          r_full, n_full;

    logic                          w_accept;
    logic                          w_out_free;
    logic                          w_table_full;
    logic                          w_ins_ok;
    logic [srtl_pkg::ADDR_W-1:0]   w_in_addr;
    srtl_pkg::t_entry              w_new_entry;
    srtl_pkg::t_result             w_result;

    srtl_pkg::t_entry              w_entries [TABLE_DEPTH];
    srtl_pkg::t_flags              w_flags   [TABLE_DEPTH];
    srtl_pkg::t_sel                w_sel     [TABLE_DEPTH];
    logic [TABLE_DEPTH-1:0]        w_a_sel;
    logic [TABLE_DEPTH-1:0]        w_b_sel;

    srtl_pkg::t_entry              w_a_entry, w_b_entry;
    logic [IDX_W-1:0]              w_a_idx, w_b_idx;
    logic                          w_a_any, w_b_any;

    // Handshake
    assign w_out_free    = !r_out_valid || m_axis_tready;
    assign s_axis_tready = (r_phase == PH_IDLE) || ((r_phase == PH_DEC) && w_out_free);
    assign w_accept      = s_axis_tvalid && s_axis_tready;
    assign w_in_addr     = s_axis_tdata[63:0];

    assign w_table_full = (r_count == CNT_W'(TABLE_DEPTH));
    assign w_ins_ok     = (r_phase == PH_SEL) && (r_op == srtl_pkg::OP_INSERT) && !w_table_full;

    assign w_new_entry.base = r_addr;
    assign w_new_entry.len  = r_size;
    assign w_new_entry.kind = r_kind;

    // Row of slot cells, each wired to its neighbors
    for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
        srtl_pkg::t_cell_ctl w_ctl;
        srtl_pkg::t_nbr      w_nbr;
        srtl_pkg::t_entry    w_prev_entry;

        assign w_ctl.cmp      = w_accept;
        assign w_ctl.ins      = w_ins_ok;
        assign w_ctl.occ      = (CNT_W'(g) < r_count);
        assign w_ctl.at_count = (CNT_W'(g) == r_count);

        if (g == 0) begin : g_first
            assign w_nbr.prev_ge = 1'b0;
            assign w_nbr.prev_lt = 1'b1;
            assign w_prev_entry  = w_new_entry;
        end else begin : g_inner
            assign w_nbr.prev_ge = w_flags[g-1].ge;
            assign w_nbr.prev_lt = w_flags[g-1].lt;
            assign w_prev_entry  = w_entries[g-1];
        end

        if (g == TABLE_DEPTH - 1) begin : g_last
            assign w_nbr.next_le = 1'b0;
            assign w_nbr.next_lt = 1'b0;
        end else begin : g_body
            assign w_nbr.next_le = w_flags[g+1].le;
            assign w_nbr.next_lt = w_flags[g+1].lt;
        end

        srtl_cell u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_ctl        (w_ctl),
            .i_addr       (w_in_addr),
            .i_new_entry  (w_new_entry),
            .i_prev_entry (w_prev_entry),
            .i_nbr        (w_nbr),
            .o_entry      (w_entries[g]),
            .o_flags      (w_flags[g]),
            .o_sel        (w_sel[g])
        );

        assign w_a_sel[g] = (r_op == srtl_pkg::OP_CONTAIN) ? w_sel[g].c_prev : w_sel[g].p_prev;
        assign w_b_sel[g] = w_sel[g].nxt_gt;
    end

    srtl_pick #(
        .DEPTH (TABLE_DEPTH),
        .IDX_W (IDX_W)
    ) u_pick_a (
        .i_sel     (w_a_sel),
        .i_entries (w_entries),
        .o_entry   (w_a_entry),
        .o_idx     (w_a_idx),
        .o_any     (w_a_any)
    );

    srtl_pick #(
        .DEPTH (TABLE_DEPTH),
        .IDX_W (IDX_W)
    ) u_pick_b (
        .i_sel     (w_b_sel),
        .i_entries (w_entries),
        .o_entry   (w_b_entry),
        .o_idx     (w_b_idx),
        .o_any     (w_b_any)
    );

    // Latch the candidates; an insert lands just above the last lower base
    always_comb begin
        n_cand_a  = r_cand_a;
        n_cand_b  = r_cand_b;
        n_ins_pos = r_ins_pos;
        n_full    = r_full;
        if (r_phase == PH_SEL) begin
            n_cand_a.have  = w_a_any;
            n_cand_a.pos   = srtl_pkg::POS_W'(w_a_idx);
            n_cand_a.entry = w_a_entry;
            n_cand_b.have  = w_b_any;
            n_cand_b.pos   = srtl_pkg::POS_W'(w_b_idx);
            n_cand_b.entry = w_b_entry;
            n_ins_pos      = w_a_any ? srtl_pkg::POS_W'(IDX_W'(w_a_idx + IDX_W'(1))) : '0;
            n_full         = w_table_full;
        end
    end

    srtl_merge u_merge (
        .i_clk     (i_clk),
        .i_diff_en (r_phase == PH_DIFF),
        .i_op      (r_op),
        .i_addr    (r_addr),
        .i_thr     (r_thr),
        .i_cand_a  (r_cand_a),
        .i_cand_b  (r_cand_b),
        .i_ins_pos (r_ins_pos),
        .i_full    (r_full),
        .o_result  (w_result)
    );

    // Sequence one item through select, distance and decide
    always_comb begin
        n_phase = r_phase;
        unique case (r_phase)
            PH_IDLE: begin
                if (w_accept) begin
                    n_phase = PH_SEL;
                end
            end
            PH_SEL: begin
                n_phase = PH_DIFF;
            end
            PH_DIFF: begin
                n_phase = PH_DEC;
            end
            PH_DEC: begin
                if (w_out_free) begin
                    n_phase = w_accept ? PH_SEL : PH_IDLE;
                end
            end
            default: begin
                n_phase = PH_IDLE;
            end
        endcase
    end

    // Advance the fill count on a stored insert
    assign n_count = w_ins_ok ? CNT_W'(r_count + CNT_W'(1)) : r_count;

    // Load the result register, drop it once taken
    always_comb begin
        n_out       = r_out;
        n_out_valid = r_out_valid;
        if ((r_phase == PH_DEC) && w_out_free) begin
            n_out       = w_result;
            n_out_valid = 1'b1;
        end else if (m_axis_tready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_phase     <= n_phase;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    // Hold the accepted beat and the stage payload
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_op   <= s_axis_tuser;
            r_addr <= s_axis_tdata[63:0];
            r_size <= s_axis_tdata[95:64];
            r_kind <= s_axis_tdata[99:96];
            r_thr  <= s_axis_tdata[131:100];
        end
        r_cand_a  <= n_cand_a;
        r_cand_b  <= n_cand_b;
        r_ins_pos <= n_ins_pos;
        r_full    <= n_full;
        r_out     <= n_out;
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_out.status;
    assign m_axis_tdata  = {{(srtl_pkg::M_TDATA_W - RES_W + srtl_pkg::ST_W){1'b0}},
                            r_out.entry.kind, r_out.entry.len, r_out.entry.base, r_out.pos};

    // Fill count never passes the table depth
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(TABLE_DEPTH))
        else $error("fill count beyond table depth");

    // Sorted order gives at most one lower boundary slot
    a_sel_a_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_SEL) |-> $onehot0(w_a_sel))
        else $error("several lower candidates marked");

    // Sorted order gives at most one upper boundary slot
    a_sel_b_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_SEL) |-> $onehot0(w_b_sel))
        else $error("several upper candidates marked");

    // A stored insert grows the table by exactly one slot
    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ins_ok |=> (r_count == CNT_W'($past(r_count) + CNT_W'(1))))
        else $error("fill count did not advance on insert");

    // A new result never overwrites one still waiting
    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !m_axis_tready) |=> ($stable(r_out) && r_out_valid))
        else $error("waiting result overwritten");

endmodule

/* design/srtl_cell.sv */
// One slot of the sorted range table: stored entry, compare flags, boundary marks.
// Depends on srtl_pkg; instantiated once per slot by the top level.
module srtl_cell (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  srtl_pkg::t_cell_ctl              i_ctl,
    input  logic [srtl_pkg::ADDR_W-1:0]      i_addr,
    input  srtl_pkg::t_entry                 i_new_entry,
    input  srtl_pkg::t_entry                 i_prev_entry,
    input  srtl_pkg::t_nbr                   i_nbr,
    output srtl_pkg::t_entry                 o_entry,
    output srtl_pkg::t_flags                 o_flags,
    output srtl_pkg::t_sel                   o_sel
);

    srtl_pkg::t_entry r_entry, n_entry;
    srtl_pkg::t_flags r_flags, n_flags;

    // Compare the stored base against the address of the accepted beat
    always_comb begin
        n_flags = r_flags;
        if (i_ctl.cmp) begin
            n_flags.le = i_ctl.occ && (r_entry.base <= i_addr);
            n_flags.lt = i_ctl.occ && (r_entry.base <  i_addr);
            n_flags.ge = i_ctl.occ && (r_entry.base >= i_addr);
        end
    end

    // Insert: take the neighbor's entry when it moves up, else load the new one if this is the insert slot
    always_comb begin
        n_entry = r_entry;
        if (i_ctl.ins) begin
            if (i_nbr.prev_ge) begin
                n_entry = i_prev_entry;
            end else if (r_flags.ge || i_ctl.at_count) begin
                n_entry = i_new_entry;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_flags <= '0;
        end else begin
            r_flags <= n_flags;
        end
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

    // Mark the boundaries of the sorted order from the neighbor flags
    assign o_sel.c_prev = r_flags.le && !i_nbr.next_le;
    assign o_sel.p_prev = r_flags.lt && !i_nbr.next_lt;
    assign o_sel.nxt_gt = r_flags.ge && i_nbr.prev_lt && !r_flags.le;

    assign o_entry = r_entry;
    assign o_flags = r_flags;

endmodule

/* design/srtl_pick.sv */
// One-hot selection of a table entry and encoding of its slot index.
// Depends on srtl_pkg; used by the top level for the two lookup candidates.
module srtl_pick #(
    parameter int DEPTH = 64,
    parameter int IDX_W = 6
) (
    input  logic [DEPTH-1:0]   i_sel,
    input  srtl_pkg::t_entry   i_entries [DEPTH],
    output srtl_pkg::t_entry   o_entry,
    output logic [IDX_W-1:0]   o_idx,
    output logic               o_any
);

    localparam int ENTRY_W = $bits(srtl_pkg::t_entry);

    // Merge the masked slots; at most one mark is set
    always_comb begin
        logic [ENTRY_W-1:0] acc;
        logic [IDX_W-1:0]   idx;
        acc = '0;
        idx = '0;
        for (int i = 0; i < DEPTH; i++) begin
            acc = acc | (i_entries[i] & {ENTRY_W{i_sel[i]}});
            idx = idx | (IDX_W'(i) & {IDX_W{i_sel[i]}});
        end
        o_entry = srtl_pkg::t_entry'(acc);
        o_idx   = idx;
    end

    assign o_any = |i_sel;

endmodule

/* design/srtl_merge.sv */
// Distance computation and result selection for all three operations.
// Depends on srtl_pkg; fed by the candidate registers of the top level.
module srtl_merge (
    input  logic                             i_clk,
    input  logic                             i_diff_en,
    input  logic [srtl_pkg::OP_W-1:0]        i_op,
    input  logic [srtl_pkg::ADDR_W-1:0]      i_addr,
    input  logic [srtl_pkg::LEN_W-1:0]       i_thr,
    input  srtl_pkg::t_cand                  i_cand_a,
    input  srtl_pkg::t_cand                  i_cand_b,
    input  logic [srtl_pkg::POS_W-1:0]       i_ins_pos,
    input  logic                             i_full,
    output srtl_pkg::t_result                o_result
);

    logic [srtl_pkg::ADDR_W-1:0] r_off_a, n_off_a;
    logic [srtl_pkg::ADDR_W-1:0] r_db, n_db;

    logic [srtl_pkg::ADDR_W-1:0] w_len_a;
    logic [srtl_pkg::ADDR_W-1:0] w_thr;
    logic [srtl_pkg::ADDR_W-1:0] w_gap_a;
    logic                        w_a_ok;
    logic                        w_b_ok;

    // Offset past the lower candidate and gap up to the upper one
    always_comb begin
        n_off_a = r_off_a;
        n_db    = r_db;
        if (i_diff_en) begin
            n_off_a = i_addr - i_cand_a.entry.base;
            n_db    = i_cand_b.entry.base - i_addr;
        end
    end

    always_ff @(posedge i_clk) begin
        r_off_a <= n_off_a;
        r_db    <= n_db;
    end

    assign w_len_a = {{(srtl_pkg::ADDR_W-srtl_pkg::LEN_W){1'b0}}, i_cand_a.entry.len};
    assign w_thr   = {{(srtl_pkg::ADDR_W-srtl_pkg::LEN_W){1'b0}}, i_thr};
    assign w_gap_a = r_off_a - w_len_a;

    // Lower candidate must lie fully below the address; ties go to it
    assign w_a_ok = i_cand_a.have && (r_off_a >= w_len_a) && (w_gap_a <= w_thr);
    assign w_b_ok = i_cand_b.have && (w_a_ok ? (r_db < w_gap_a) : (r_db <= w_thr));

    // Build the result beat
    always_comb begin
        o_result        = '0;
        o_result.status = srtl_pkg::ST_NONE;
        unique case (i_op)
            srtl_pkg::OP_INSERT: begin
                if (i_full) begin
                    o_result.status = srtl_pkg::ST_FULL;
                end else begin
                    o_result.status = srtl_pkg::ST_OK;
                    o_result.pos    = i_ins_pos;
                end
            end
            srtl_pkg::OP_CONTAIN: begin
                if (i_cand_a.have && (r_off_a < w_len_a)) begin
                    o_result.status = srtl_pkg::ST_OK;
                    o_result.pos    = i_cand_a.pos;
                    o_result.entry  = i_cand_a.entry;
                end
            end
            srtl_pkg::OP_NEARBY: begin
                if (w_b_ok) begin
                    o_result.status = srtl_pkg::ST_OK;
                    o_result.pos    = i_cand_b.pos;
                    o_result.entry  = i_cand_b.entry;
                end else if (w_a_ok) begin
                    o_result.status = srtl_pkg::ST_OK;
                    o_result.pos    = i_cand_a.pos;
                    o_result.entry  = i_cand_a.entry;
                end
            end
            default: begin
                o_result.status = srtl_pkg::ST_NONE;
            end
        endcase
    end

endmodule
